[sv/skht_pkg.sv]
// Shared constants, codes and types for the string-keyed hash table.
`timescale 1ns / 1ps
`default_nettype none
package skht_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int KEY_MAX  = 16;
  localparam int LEN_W    = $clog2(KEY_MAX + 1);
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] CMD_PUT      = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

  typedef struct packed {
    logic [31:0]              hash;
    logic [LEN_W-1:0]         klen;
    logic [31:0]              handle;
    logic [KEY_MAX-1:0][7:0]  bytes;
  } slot_row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                idle;
    logic                probe_start;
    logic                rd_probe;
    logic                probe_adv;
    logic                put_write;
    logic                ins_write;
    logic                del_start;
    logic                del_rd;
    logic                del_copy;
    logic                del_step;
    logic                del_end;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_found;
    logic                out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       accept_last;
    logic       overflow;
    logic [1:0] command;
    logic       handle_zero;
    logic       full_load;
    logic       probe_valid;
    logic       probe_match;
    logic       probe_last;
    logic       del_done;
    logic       cand_valid;
    logic       stays;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

[sv/skht_if.sv]
// Request and response channel interfaces of the hash table.
`timescale 1ns / 1ps
`default_nettype none
interface skht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  name_byte;
  logic        last_byte;
  logic [31:0] kernel_handle;
  modport source (output valid, command, name_byte, last_byte, kernel_handle, input ready);
  modport sink (input valid, command, name_byte, last_byte, kernel_handle, output ready);
endinterface

interface skht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_handle;
  logic [6:0]  entries_in_use;
  modport source (output valid, status, found_handle, entries_in_use, input ready);
  modport sink (input valid, status, found_handle, entries_in_use, output ready);
endinterface
`default_nettype wire

[sv/string_keyed_hash_table.sv]
// Top level of the string-keyed hash table.
// A key name arrives one byte per request and is folded into a 32-bit FNV-1a hash. The
// last byte's command (put, remove, lookup) then runs a linear probe over a 64-slot
// table held in one single-port-read RAM; each slot visited is first read and then
// compared, and a remove then shifts the following cluster backward. A request with
// a name over 16 bytes, an invalid command or a put of handle zero is rejected before
// the probe. The next name is taken once the result sits in the output register. Puts
// of new names are refused as table full at three-quarters load.
`timescale 1ns / 1ps
`default_nettype none
module string_keyed_hash_table (
  input wire logic   clk,
  input wire logic   rst,
  skht_req_if.sink   req_ch,
  skht_rsp_if.source rsp_ch
);
  skht_pkg::cmd_t  cmd;
  skht_pkg::stat_t st;

  skht_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  skht_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch),
    .cmd    (cmd),
    .st     (st)
  );
endmodule
`default_nettype wire

[sv/skht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module skht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[sv/skht_dp.sv]
// Datapath: key hashing and buffering, slot table, probe pointers and result register.
`timescale 1ns / 1ps
`default_nettype none
module skht_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  skht_req_if.sink            req_ch,
  skht_rsp_if.source          rsp_ch,
  input  wire skht_pkg::cmd_t cmd,
  output skht_pkg::stat_t     st
);
  localparam int SW = skht_pkg::SLOT_W;

  logic [31:0]                        hash;
  logic [skht_pkg::KEY_MAX-1:0][7:0]  key_buf;
  logic [skht_pkg::LEN_W-1:0]         key_len;
  logic                               ovf;
  logic [1:0]                         op;
  logic [31:0]                        handle;
  logic [skht_pkg::SLOTS-1:0]         valid;
  logic [skht_pkg::CNT_W-1:0]         count;
  logic [SW-1:0]                      s;
  logic [SW-1:0]                      hole;
  logic [SW-1:0]                      j;
  logic [SW:0]                        n;
  logic [skht_pkg::STATUS_W-1:0]      res_code;
  logic [31:0]                        res_found;
  logic                               out_valid;
  logic [skht_pkg::STATUS_W-1:0]      out_status;
  logic [31:0]                        out_found;
  logic [skht_pkg::CNT_W-1:0]         out_count;

  logic                               accept;
  logic [31:0]                        hash_next;
  logic [skht_pkg::KEY_MAX-1:0][7:0]  key_masked;
  logic [SW-1:0]                      cand;
  logic [SW-1:0]                      home;
  logic                               wr_en;
  logic [SW-1:0]                      wr_addr;
  skht_pkg::slot_row_t                wr_row;
  skht_pkg::slot_row_t                rd_row;
  logic [SW-1:0]                      rd_addr;

  assign accept    = req_ch.valid && cmd.idle;
  assign req_ch.ready = cmd.idle;
  assign hash_next = (hash ^ {24'd0, req_ch.name_byte}) * skht_pkg::FNV_PRIME;
  assign cand      = j + 1'b1;
  assign home      = rd_row.hash[SW-1:0];

  always_comb begin
    for (int i = 0; i < skht_pkg::KEY_MAX; i++) begin
      key_masked[i] = (skht_pkg::LEN_W'(i) < key_len) ? key_buf[i] : 8'd0;
    end
  end

  skht_ram #(
    .WIDTH ($bits(skht_pkg::slot_row_t)),
    .DEPTH (skht_pkg::SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  assign rd_addr = cmd.del_rd ? cand : s;

  always_comb begin
    wr_en   = cmd.put_write || cmd.ins_write || cmd.del_copy;
    wr_addr = cmd.del_copy ? hole : s;
    wr_row  = rd_row;
    if (cmd.put_write) begin
      wr_row.handle = handle;
    end else if (cmd.ins_write) begin
      wr_row.hash   = hash;
      wr_row.klen   = key_len;
      wr_row.handle = handle;
      wr_row.bytes  = key_masked;
    end
  end

  always_comb begin
    st.accept_last = accept && req_ch.last_byte;
    st.overflow    = ovf;
    st.command     = op;
    st.handle_zero = (handle == 32'd0);
    st.full_load   = ({count, 2'b00} >= (skht_pkg::CNT_W + 2)'(skht_pkg::SLOTS * 3));
    st.probe_valid = valid[s];
    st.probe_match = (rd_row.hash == hash) && (rd_row.klen == key_len)
                     && (rd_row.bytes == key_masked);
    st.probe_last  = (n == (SW + 1)'(skht_pkg::SLOTS - 1));
    st.del_done    = (n == (SW + 1)'(skht_pkg::SLOTS));
    st.cand_valid  = valid[cand];
    // The entry at j stays if its home lies cyclically in (hole, j].
    if (hole <= j) begin
      st.stays = (hole < home) && (home <= j);
    end else begin
      st.stays = (hole < home) || (home <= j);
    end
    st.out_free = !out_valid || rsp_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= skht_pkg::FNV_BASIS;
      key_len   <= '0;
      ovf       <= 1'b0;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        hash <= hash_next;
        if (key_len < skht_pkg::LEN_W'(skht_pkg::KEY_MAX)) begin
          key_buf[key_len[skht_pkg::LEN_W-2:0]] <= req_ch.name_byte;
          key_len <= key_len + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.ins_write) begin
        valid[s] <= 1'b1;
        count    <= count + 1'b1;
      end
      if (cmd.del_end) begin
        valid[hole] <= 1'b0;
        count       <= count - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        hash      <= skht_pkg::FNV_BASIS;
        key_len   <= '0;
        ovf       <= 1'b0;
      end else if (rsp_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req_ch.command;
      handle <= req_ch.kernel_handle;
    end
    if (cmd.probe_start) begin
      s <= hash[SW-1:0];
      n <= '0;
    end
    if (cmd.probe_adv) begin
      s <= s + 1'b1;
      n <= n + 1'b1;
    end
    if (cmd.del_start) begin
      hole <= s;
      j    <= s;
      n    <= (SW + 1)'(1);
    end
    if (cmd.del_rd) begin
      j <= cand;
    end
    if (cmd.del_copy) begin
      hole <= j;
    end
    if (cmd.del_step) begin
      n <= n + 1'b1;
    end
    if (cmd.res_set) begin
      res_code  <= cmd.res_code;
      res_found <= cmd.res_found ? rd_row.handle : 32'd0;
    end
    if (cmd.out_load) begin
      out_status <= res_code;
      out_found  <= res_found;
      out_count  <= count;
    end
  end

  assign rsp_ch.valid          = out_valid;
  assign rsp_ch.status         = out_status;
  assign rsp_ch.found_handle   = out_found;
  assign rsp_ch.entries_in_use = out_count;

`ifndef ASSERT_OFF
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count differs from number of valid slots");
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> !st.full_load)
    else $error("insert above the load limit");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.put_write, cmd.ins_write, cmd.del_copy}))
    else $error("two slot writes in one cycle");
  a_found_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == skht_pkg::ST_OK || out_found == 32'd0))
    else $error("handle reported with a failing status");
`endif
endmodule
`default_nettype wire

[sv/skht_ctrl.sv]
// Controller state machine: command decode, probe walk and backward-shift delete.
`timescale 1ns / 1ps
`default_nettype none
module skht_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire skht_pkg::stat_t st,
  output skht_pkg::cmd_t       cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PRD   = 3'd2;
  localparam logic [2:0] S_PRC   = 3'd3;
  localparam logic [2:0] S_DRD   = 3'd4;
  localparam logic [2:0] S_DRC   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       hit;
  logic       miss;

  always_comb begin
    cmd        = '0;
    state_next = state;
    hit        = st.probe_valid && st.probe_match;
    miss       = !st.probe_valid || (!st.probe_match && st.probe_last);
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (st.accept_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.overflow) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = skht_pkg::ST_TOO_LONG;
          state_next   = S_FIN;
        end else if ((st.command != skht_pkg::CMD_PUT && st.command != skht_pkg::CMD_REMOVE
                      && st.command != skht_pkg::CMD_LOOKUP)
                     || (st.command == skht_pkg::CMD_PUT && st.handle_zero)) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = skht_pkg::ST_INVALID;
          state_next   = S_FIN;
        end else begin
          cmd.probe_start = 1'b1;
          state_next      = S_PRD;
        end
      end
      S_PRD: begin
        cmd.rd_probe = 1'b1;
        state_next   = S_PRC;
      end
      S_PRC: begin
        if (hit) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = skht_pkg::ST_OK;
          case (st.command)
            skht_pkg::CMD_PUT: begin
              cmd.put_write = 1'b1;
              state_next    = S_FIN;
            end
            skht_pkg::CMD_REMOVE: begin
              cmd.del_start = 1'b1;
              state_next    = S_DRD;
            end
            default: begin
              cmd.res_found = 1'b1;
              state_next    = S_FIN;
            end
          endcase
        end else if (miss) begin
          cmd.res_set = 1'b1;
          state_next  = S_FIN;
          if (st.command == skht_pkg::CMD_PUT) begin
            // An empty slot was found unless the whole table was walked.
            if (st.full_load || st.probe_valid) begin
              cmd.res_code = skht_pkg::ST_FULL;
            end else begin
              cmd.res_code  = skht_pkg::ST_OK;
              cmd.ins_write = 1'b1;
            end
          end else begin
            cmd.res_code = skht_pkg::ST_NOT_FOUND;
          end
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = S_PRD;
        end
      end
      S_DRD: begin
        if (st.del_done || !st.cand_valid) begin
          cmd.del_end = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.del_rd = 1'b1;
          state_next = S_DRC;
        end
      end
      S_DRC: begin
        cmd.del_copy = !st.stays;
        cmd.del_step = 1'b1;
        state_next   = S_DRD;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire
